// ===== design/stsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table search/insert package
// Shared constants, command codes and beat types for the sorted table core.
// ----------------------------------------------------------------------------
package stsi_pkg;

    // Field widths of the request and response beats.
    localparam int KEY_W      = 31;
    localparam int IDX_W      = 4;
    localparam int POSITION_W = 5;

    // Default number of slots in the table.
    localparam int TABLE_DEPTH = 16;

    // Request command codes.
    typedef enum logic {
        CMD_SEARCH = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    // One request beat.
    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] index;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
        logic                  inserted;
        logic                  overflow;
        logic [KEY_W-1:0]      read_value;
    } rsp_t;

endpackage

// ===== design/stsi_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted table slot cell
// Holds one table entry, compares it with the search key and, on an insert,
// either loads the key, takes the entry of its lower neighbor or keeps its own.
// ----------------------------------------------------------------------------
module stsi_cell #(
    parameter int SLOT  = 0,
    parameter int POS_W = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [stsi_pkg::KEY_W-1:0] key,
    input  logic [stsi_pkg::KEY_W-1:0] left_entry,
    input  logic                     upd,
    input  logic [POS_W-1:0]         ins_pos,
    output logic [stsi_pkg::KEY_W-1:0] entry,
    output logic                     eq,
    output logic                     gt
);
    import stsi_pkg::*;

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             is_ins_slot;
    logic             is_above;

    // Compare the stored entry with the broadcast key.
    assign eq = (entry_reg == key);
    assign gt = (entry_reg != '0) && (key > entry_reg);

    // Place of this slot relative to the insertion slot.
    assign is_ins_slot = (ins_pos == POS_W'(SLOT));
    assign is_above    = (POS_W'(SLOT) > ins_pos);

    // Load the key at the insertion slot, shift up above it.
    always_comb
    begin
        entry_next = entry_reg;
        if (upd)
        begin
            if (is_ins_slot)
                entry_next = key;
            else if (is_above)
                entry_next = left_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/stsi_locate.sv =====
// ----------------------------------------------------------------------------
// Sorted table match and insertion locator
// Reduces the per-cell compare flags to the lowest matching slot and the
// slot just past the last smaller entry.
// ----------------------------------------------------------------------------
module stsi_locate #(
    parameter int DEPTH = 16,
    parameter int POS_W = 5
) (
    input  logic [DEPTH-1:0] eq,
    input  logic [DEPTH-1:0] gt,
    output logic             hit,
    output logic [POS_W-1:0] match_pos,
    output logic [POS_W-1:0] ins_pos
);

    // Lowest matching slot: scan downward so the lowest hit wins.
    always_comb
    begin
        match_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (eq[i])
                match_pos = POS_W'(i);
        end
    end

    assign hit = |eq;

    // One past the highest slot holding a smaller nonzero entry.
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (gt[i])
                ins_pos = POS_W'(i + 1);
        end
    end

endmodule

// ===== design/sorted_table_search_insert_core.sv =====
// ----------------------------------------------------------------------------
// Sorted table search and insert core
// An ascending table of nonzero keys kept in a row of slot cells.
// ----------------------------------------------------------------------------
// The core takes one request beat per clock cycle while req_stall is low and
// returns one response beat for each in the next cycle. Every slot cell
// compares its entry with the key in parallel; the table is updated at the
// same clock edge at which the request is accepted, so the next request sees
// the new table. The response sits in an output register; req_stall is raised
// only while that register holds a response that is stalled downstream. The
// table is cleared by reset directly, with no clearing pass. A read request
// returns the entry at index, or zero when index is at or past DEPTH.
// ----------------------------------------------------------------------------
module sorted_table_search_insert_core #(
    parameter int DEPTH = stsi_pkg::TABLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  stsi_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output stsi_pkg::rsp_t rsp
);
    import stsi_pkg::*;

    localparam int POS_W = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] entries [DEPTH];
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] gt;
    logic             hit;
    logic [POS_W-1:0] match_pos;
    logic [POS_W-1:0] ins_pos;
    logic             accept;
    logic             upd;
    logic [KEY_W-1:0] rd_value;
    rsp_t             rsp_next;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    assign accept    = req_valid && !req_stall;
    assign req_stall = rsp_valid_reg && rsp_stall;

    // Row of slot cells; each takes its lower neighbor's entry on a shift.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [KEY_W-1:0] left;
        if (g == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_rest
            assign left = entries[g-1];
        end

        stsi_cell #(
            .SLOT  (g),
            .POS_W (POS_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .key        (req.key),
            .left_entry (left),
            .upd        (upd),
            .ins_pos    (ins_pos),
            .entry      (entries[g]),
            .eq         (eq[g]),
            .gt         (gt[g])
        );
    end

    stsi_locate #(
        .DEPTH (DEPTH),
        .POS_W (POS_W)
    ) u_locate (
        .eq        (eq),
        .gt        (gt),
        .hit       (hit),
        .match_pos (match_pos),
        .ins_pos   (ins_pos)
    );

    // Insert only on an accepted search with a new nonzero key and room.
    assign upd = accept && (req.cmd == CMD_SEARCH) && (req.key != '0) && !hit &&
                 (ins_pos != POS_W'(DEPTH));

    // Read port: selected entry, zero past the end of the table.
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (32'(req.index) == i)
                rd_value = entries[i];
        end
    end

    // Response fields for the current request.
    always_comb
    begin
        rsp_next = '0;
        if (req.cmd == CMD_READ)
            rsp_next.read_value = rd_value;
        else if (req.key != '0)
        begin
            if (hit)
            begin
                rsp_next.found    = 1'b1;
                rsp_next.position = POSITION_W'(match_pos);
            end
            else if (ins_pos == POS_W'(DEPTH))
            begin
                rsp_next.position = POSITION_W'(ins_pos);
                rsp_next.overflow = 1'b1;
            end
            else
            begin
                rsp_next.position = POSITION_W'(ins_pos);
                rsp_next.inserted = 1'b1;
                rsp_next.overflow = (entries[DEPTH-1] != '0);
            end
        end
    end

    // Output register: loads on accept, empties when the beat is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/stsi_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table core port checker
// Watches the core's ports and flags responses or handshakes that break
// the core's behavior.
// ----------------------------------------------------------------------------
module stsi_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input stsi_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input stsi_pkg::rsp_t rsp
);

    // A stalled response must block new requests.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> req_stall)
        else $error("request accepted over a stalled response");

    // Every accepted request gives a response in the next cycle.
    a_rsp_next: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted request produced no response");

    // A key already present is neither inserted nor an overflow.
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found) |-> (!rsp.inserted && !rsp.overflow))
        else $error("found response also reports insert or overflow");

    // A nonzero read value only comes with an otherwise empty response.
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.read_value != '0)) |->
        (!rsp.found && !rsp.inserted && !rsp.overflow && (rsp.position == '0)))
        else $error("read response carries search fields");

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind sorted_table_search_insert_core stsi_checker u_stsi_checker (.*);

// ===== tb/sv/sorted_table_search_insert_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table search and insert core testbench
// Walks a short table of directed requests through the core. These cover an
// empty table, a zero key, hits, inserts at the head and tail, a full table,
// a refused key and a dropped tail entry. It then sends about 1100 random
// requests, with random gaps and downstream stalls. Every response beat is
// checked field by field against a hand-typed response or a behavioral copy.
// ----------------------------------------------------------------------------
module sorted_table_search_insert_core_test;
    import stsi_pkg::*;

    localparam int RANDOM_BEATS = 1100;
    localparam int IDLE_LIMIT   = 2000;

    // One row of the directed table. When has_want is set, want is the
    // response typed in by hand; otherwise the table copy supplies it.
    typedef struct {
        req_t beat;
        bit   has_want;
        rsp_t want;
    } stim_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // Behavioral copy of the table and the responses still owed by the core.
    logic [KEY_W-1:0] slot_keys [TABLE_DEPTH];
    rsp_t             pending_rsp_q [$];
    stim_row_t        directed_rows [$];

    int mismatch_count = 0;
    int checked_count  = 0;
    int idle_cycles    = 0;
    int read_count     = 0;
    int hit_count      = 0;
    int insert_count   = 0;
    int drop_count     = 0;
    int refused_count  = 0;
    int zero_key_count = 0;

    sorted_table_search_insert_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic rsp_t make_rsp(input logic fnd, input int pos, input logic ins,
                                      input logic ovf, input logic [KEY_W-1:0] value);
        rsp_t r;
        r.found      = fnd;
        r.position   = POSITION_W'(pos);
        r.inserted   = ins;
        r.overflow   = ovf;
        r.read_value = value;
        return r;
    endfunction

    function automatic stim_row_t make_row(input cmd_t c, input logic [KEY_W-1:0] k,
                                           input logic [IDX_W-1:0] i, input bit has_want,
                                           input rsp_t want);
        stim_row_t row;
        row.beat.cmd   = c;
        row.beat.key   = k;
        row.beat.index = i;
        row.has_want   = has_want;
        row.want       = want;
        return row;
    endfunction

    // Applies one request to the table copy and returns the response it causes.
    function automatic rsp_t table_search_insert(input req_t beat);
        rsp_t res;
        int   hit_slot;
        int   ins_slot;
        res = '0;
        if (beat.cmd == CMD_READ)
        begin
            if (beat.index < TABLE_DEPTH)
                res.read_value = slot_keys[beat.index];
            return res;
        end
        if (beat.key == '0)
            return res;

        // Lowest matching slot wins.
        hit_slot = -1;
        for (int s = TABLE_DEPTH - 1; s >= 0; s--)
            if (slot_keys[s] == beat.key)
                hit_slot = s;
        if (hit_slot >= 0)
        begin
            res.found    = 1'b1;
            res.position = POSITION_W'(hit_slot);
            return res;
        end

        // Insert just after the last smaller nonzero entry.
        ins_slot = 0;
        for (int s = 0; s < TABLE_DEPTH; s++)
            if (slot_keys[s] != '0 && beat.key > slot_keys[s])
                ins_slot = s + 1;
        if (ins_slot >= TABLE_DEPTH)
        begin
            res.position = POSITION_W'(TABLE_DEPTH);
            res.overflow = 1'b1;
            return res;
        end
        res.overflow = (slot_keys[TABLE_DEPTH-1] != '0);
        for (int s = TABLE_DEPTH - 1; s > ins_slot; s--)
            slot_keys[s] = slot_keys[s-1];
        slot_keys[ins_slot] = beat.key;
        res.inserted = 1'b1;
        res.position = POSITION_W'(ins_slot);
        return res;
    endfunction

    // Random request, biased toward keys that hit, small keys that collide
    // and the extremes of the key range.
    function automatic req_t random_beat();
        req_t beat;
        int   r;
        r          = $urandom_range(0, 99);
        beat.cmd   = CMD_SEARCH;
        beat.key   = KEY_W'($urandom());
        beat.index = IDX_W'($urandom());
        if (r < 22)
            beat.cmd = CMD_READ;
        else if (r < 45)
            beat.key = slot_keys[$urandom_range(0, TABLE_DEPTH - 1)];
        else if (r < 70)
            beat.key = KEY_W'($urandom_range(1, 200));
        else if (r < 88)
            beat.key = KEY_W'($urandom());
        else if (r < 96)
        begin
            case ($urandom_range(0, 3))
                0: beat.key = KEY_W'(1);
                1: beat.key = KEY_W'(2);
                2: beat.key = {KEY_W{1'b1}} - 1'b1;
                default: beat.key = {KEY_W{1'b1}};
            endcase
        end
        else
            beat.key = '0;
        return beat;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request beat, holds it until accepted and records the
    // response it should cause. Called right after a rising edge.
    task automatic send_beat(input req_t beat, input bit has_want, input rsp_t want);
        rsp_t predicted;
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = table_search_insert(beat);
        if (beat.cmd == CMD_READ)
            read_count++;
        else if (beat.key == '0)
            zero_key_count++;
        if (predicted.found)
            hit_count++;
        if (predicted.inserted)
            insert_count++;
        if (predicted.inserted && predicted.overflow)
            drop_count++;
        if (!predicted.inserted && predicted.overflow)
            refused_count++;
        pending_rsp_q.push_back(has_want ? want : predicted);
    endtask

    // Drops the request valid for the given gap after a beat, if nonzero.
    task automatic idle_after(input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Check every response beat against the oldest outstanding one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: expected no response beat, got %p", $time, rsp);
            end
            else
            begin
                rsp_t want;
                want = pending_rsp_q.pop_front();
                checked_count++;
                compare_field("found", 32'(want.found), 32'(rsp.found));
                compare_field("position", 32'(want.position), 32'(rsp.position));
                compare_field("inserted", 32'(want.inserted), 32'(rsp.inserted));
                compare_field("overflow", 32'(want.overflow), 32'(rsp.overflow));
                compare_field("read_value", 32'(want.read_value), 32'(rsp.read_value));
            end
        end
    end

    // Watchdog: too long without a beat on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: timed out with %0d responses outstanding",
                         $time, pending_rsp_q.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Downstream stalls: free-running stretches, short stalls and a few long.
    initial
    begin
        int r;
        int run;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                run = $urandom_range(1, 30);
                rsp_stall <= 1'b0;
            end
            else if (r < 90)
            begin
                run = $urandom_range(1, 3);
                rsp_stall <= 1'b1;
            end
            else
            begin
                run = $urandom_range(10, 40);
                rsp_stall <= 1'b1;
            end
            repeat (run) @(posedge clk);
        end
    end

    // Reset, directed rows, random requests, drain and verdict.
    initial
    begin
        rsp_t none;
        req_t beat;
        none = '0;
        for (int s = 0; s < TABLE_DEPTH; s++)
            slot_keys[s] = '0;

        // Empty table, zero key, first insert and its hit, a key below all.
        directed_rows.push_back(make_row(CMD_READ, '0, 4'd0, 1, make_rsp(0, 0, 0, 0, '0)));
        directed_rows.push_back(make_row(CMD_READ, '1, 4'd15, 1, make_rsp(0, 0, 0, 0, '0)));
        directed_rows.push_back(make_row(CMD_SEARCH, '0, 4'd15, 1, make_rsp(0, 0, 0, 0, '0)));
        directed_rows.push_back(make_row(CMD_SEARCH, 31'd1000, '0, 1,
                                         make_rsp(0, 0, 1, 0, '0)));
        directed_rows.push_back(make_row(CMD_SEARCH, 31'd1000, '1, 1,
                                         make_rsp(1, 0, 0, 0, '0)));
        directed_rows.push_back(make_row(CMD_SEARCH, 31'd1, '0, 1, make_rsp(0, 0, 1, 0, '0)));
        // Fill the rest of the table in ascending order.
        for (int k = 2; k < TABLE_DEPTH; k++)
            directed_rows.push_back(make_row(CMD_SEARCH, KEY_W'(k * 1000), '0, 0, none));
        // Full table: a key above all is refused, a middle key drops the tail.
        directed_rows.push_back(make_row(CMD_SEARCH, '1, '0, 1,
                                         make_rsp(0, TABLE_DEPTH, 0, 1, '0)));
        directed_rows.push_back(make_row(CMD_SEARCH, 31'd500, '0, 1,
                                         make_rsp(0, 1, 1, 1, '0)));
        directed_rows.push_back(make_row(CMD_SEARCH, 31'd1, '0, 1, make_rsp(1, 0, 0, 0, '0)));
        directed_rows.push_back(make_row(CMD_READ, '0, 4'd15, 0, none));
        directed_rows.push_back(make_row(CMD_READ, '1, 4'd3, 0, none));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].beat, directed_rows[i].has_want, directed_rows[i].want);
            idle_after(pick_gap());
        end

        // Random part, with a back-to-back stretch every 150 beats.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            beat = random_beat();
            send_beat(beat, 0, none);
            idle_after((n % 150) < 40 ? 0 : pick_gap());
        end
        req_valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests: %0d reads, %0d zero-key searches, %0d hits, %0d inserts",
                 directed_rows.size() + RANDOM_BEATS, read_count, zero_key_count,
                 hit_count, insert_count);
        $display("%0d inserts dropped the tail entry, %0d keys refused; %0d responses checked",
                 drop_count, refused_count, checked_count);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sorted_table_search_insert_core.f =====
design/stsi_pkg.sv
design/stsi_cell.sv
design/stsi_locate.sv
design/sorted_table_search_insert_core.sv
design/stsi_checker.sv
tb/sv/sorted_table_search_insert_core_test.sv
